// File: rtl/fbpa_pkg.sv
`default_nettype none

package fbpa_pkg;

   // pool geometry
   localparam int MAX_BLOCKS  = 256;
   localparam int IDX_W       = $clog2(MAX_BLOCKS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int ALIGN_BYTES = 64;
   localparam int ALIGN_SHIFT = $clog2(ALIGN_BYTES);
   localparam int ADDR_W      = 48;
   localparam int SIZE_W      = 17;

   // derived widths, in units of the alignment except STEP_W, the divide step counter
   localparam int SU_W    = SIZE_W + 1 - ALIGN_SHIFT;
   localparam int FIRST_W = ADDR_W + 1 - ALIGN_SHIFT;
   localparam int LIMIT_W = SU_W + CNT_W - 1;
   localparam int OFFU_W  = LIMIT_W;
   localparam int PROD_W  = IDX_W + SU_W;
   localparam int DIV_W   = OFFU_W + 1;
   localparam int STEP_W  = $clog2(IDX_W);

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = ADDR_W;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_ADDRESS = 2'd2;

   // register reset values
   localparam int          RST_BLOCK_SIZE  = 64;
   localparam int          RST_BLOCK_COUNT = 256;
   localparam longint      RST_BASE        = 4096;
   localparam int          RST_SU          = (RST_BLOCK_SIZE + ALIGN_BYTES - 1) / ALIGN_BYTES;
   localparam longint      RST_FIRST       = (RST_BASE + ALIGN_BYTES - 1) / ALIGN_BYTES;

   // command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   typedef enum logic {
      OP_ACQUIRE = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK          = 2'd0,
      STAT_EMPTY       = 2'd1,
      STAT_NOT_OWNED   = 2'd2,
      STAT_DOUBLE_FREE = 2'd3
   } status_type;

   typedef struct packed {
      logic [SU_W-1:0]    stride_units;
      logic [CNT_W-1:0]   pool_count;
      logic [FIRST_W-1:0] first_units;
      logic [LIMIT_W-1:0] limit;
   } cfg_type;

   typedef struct packed {
      op_type              opcode;
      logic                reject;
      logic [OFFU_W-1:0]   off_units;
   } cmd_type;

   typedef struct packed {
      status_type          status;
      logic [ADDR_W-1:0]   granted_address;
      logic [CNT_W-1:0]    blocks_in_use;
   } rsp_word_type;

endpackage

`default_nettype wire

// File: rtl/fbpa_if.sv
`default_nettype none

interface fbpa_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [fbpa_pkg::ADDR_W-1:0]   block_address;

   modport source (output valid, output opcode, output block_address, input ready);
   modport sink   (input valid, input opcode, input block_address, output ready);
endinterface

interface fbpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic [fbpa_pkg::ADDR_W-1:0]   granted_address;
   logic [fbpa_pkg::CNT_W-1:0]    blocks_in_use;

   modport source (output valid, output status, output granted_address,
                   output blocks_in_use, input ready);
   modport sink   (input valid, input status, input granted_address,
                   input blocks_in_use, output ready);
endinterface

`default_nettype wire

// File: rtl/fbpa_csr.sv
`default_nettype none

module fbpa_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [fbpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [fbpa_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output fbpa_pkg::cfg_type                       cfg,
   output logic                                    clear
);

   logic [fbpa_pkg::SU_W-1:0]    su_ff, su_in;
   logic [fbpa_pkg::CNT_W-1:0]   n_ff, n_in;
   logic [fbpa_pkg::FIRST_W-1:0] first_ff, first_in;
   logic [fbpa_pkg::LIMIT_W-1:0] limit_ff, limit_in;

   logic [fbpa_pkg::SIZE_W:0]    size_sum;
   logic [fbpa_pkg::ADDR_W:0]    base_sum;
   logic [fbpa_pkg::SU_W-1:0]    su_new;
   logic [fbpa_pkg::CNT_W-1:0]   n_new;
   logic [fbpa_pkg::FIRST_W-1:0] first_new;

   // round up to the alignment and keep in alignment units
   assign size_sum  = {1'b0, csr_write_data[fbpa_pkg::SIZE_W-1:0]}
                      + (fbpa_pkg::SIZE_W+1)'(fbpa_pkg::ALIGN_BYTES - 1);
   assign su_new    = size_sum[fbpa_pkg::SIZE_W:fbpa_pkg::ALIGN_SHIFT];
   assign base_sum  = {1'b0, csr_write_data[fbpa_pkg::ADDR_W-1:0]}
                      + (fbpa_pkg::ADDR_W+1)'(fbpa_pkg::ALIGN_BYTES - 1);
   assign first_new = base_sum[fbpa_pkg::ADDR_W:fbpa_pkg::ALIGN_SHIFT];
   assign n_new     = (csr_write_data[fbpa_pkg::CNT_W-1:0] >
                       fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS)) ?
                      fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS) :
                      csr_write_data[fbpa_pkg::CNT_W-1:0];

   always_comb begin
      su_in    = su_ff;
      n_in     = n_ff;
      first_in = first_ff;
      limit_in = limit_ff;
      clear    = 1'b0;
      if (csr_write_enable) begin
         case (csr_index)
            fbpa_pkg::REG_BLOCK_SIZE: begin
               su_in    = su_new;
               limit_in = fbpa_pkg::LIMIT_W'(su_new) * fbpa_pkg::LIMIT_W'(n_ff);
               clear    = 1'b1;
            end
            fbpa_pkg::REG_BLOCK_COUNT: begin
               n_in     = n_new;
               limit_in = fbpa_pkg::LIMIT_W'(su_ff) * fbpa_pkg::LIMIT_W'(n_new);
               clear    = 1'b1;
            end
            fbpa_pkg::REG_BASE_ADDRESS: begin
               first_in = first_new;
               clear    = 1'b1;
            end
            default: begin
               clear = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         su_ff    <= fbpa_pkg::SU_W'(fbpa_pkg::RST_SU);
         n_ff     <= fbpa_pkg::CNT_W'(fbpa_pkg::RST_BLOCK_COUNT);
         first_ff <= fbpa_pkg::FIRST_W'(fbpa_pkg::RST_FIRST);
         limit_ff <= fbpa_pkg::LIMIT_W'(fbpa_pkg::RST_SU * fbpa_pkg::RST_BLOCK_COUNT);
      end else begin
         su_ff    <= su_in;
         n_ff     <= n_in;
         first_ff <= first_in;
         limit_ff <= limit_in;
      end
   end

   // zero size or zero count leaves the pool inert
   assign cfg.stride_units = su_ff;
   assign cfg.pool_count   = (su_ff == '0 || n_ff == '0) ? '0 : n_ff;
   assign cfg.first_units  = first_ff;
   assign cfg.limit        = limit_ff;

endmodule

`default_nettype wire

// File: rtl/fbpa_front.sv
`default_nettype none

module fbpa_front (
   input  wire logic                            req_valid,
   input  wire logic                            req_opcode,
   input  wire logic [fbpa_pkg::ADDR_W-1:0]     req_block_address,
   input  wire fbpa_pkg::cfg_type               cfg,
   input  wire logic                            push_ready,
   output logic                                 req_ready,
   output logic                                 push_valid,
   output fbpa_pkg::cmd_type                    push_cmd
);

   localparam int OFF_HI = fbpa_pkg::ADDR_W - fbpa_pkg::ALIGN_SHIFT;

   logic [fbpa_pkg::ADDR_W+1:0]   diff;
   logic                          below_base;
   logic [OFF_HI-1:0]             off_units;
   logic                          misaligned;
   logic                          in_range;

   // offset from the aligned pool start, borrow means below the pool
   assign diff       = {2'b00, req_block_address}
                       - {1'b0, cfg.first_units, fbpa_pkg::ALIGN_SHIFT'(0)};
   assign below_base = diff[fbpa_pkg::ADDR_W+1];
   assign misaligned = diff[fbpa_pkg::ALIGN_SHIFT-1:0] != '0;
   assign off_units  = diff[fbpa_pkg::ADDR_W-1:fbpa_pkg::ALIGN_SHIFT];
   assign in_range   = (off_units[OFF_HI-1:fbpa_pkg::OFFU_W] == '0)
                       && (off_units[fbpa_pkg::OFFU_W-1:0] < cfg.limit);

   always_comb begin
      push_cmd.opcode    = fbpa_pkg::op_type'(req_opcode);
      push_cmd.off_units = off_units[fbpa_pkg::OFFU_W-1:0];
      push_cmd.reject    = (req_block_address == '0) || (cfg.pool_count == '0)
                           || below_base || misaligned || !in_range;
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

`default_nettype wire

// File: rtl/fbpa_queue.sv
`default_nettype none

module fbpa_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   input  wire fbpa_pkg::cmd_type    push_cmd,
   output logic                      pop_valid,
   input  wire logic                 pop_ready,
   output fbpa_pkg::cmd_type         pop_cmd
);

   fbpa_pkg::cmd_type                 slot_ff [fbpa_pkg::QUEUE_DEPTH];
   logic [fbpa_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [fbpa_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [fbpa_pkg::QCNT_W-1:0]       fill_ff, fill_in;
   logic                              push;
   logic                              pop;

   assign push_ready = fill_ff != fbpa_pkg::QCNT_W'(fbpa_pkg::QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// File: rtl/fbpa_back.sv
`default_nettype none

module fbpa_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire fbpa_pkg::cfg_type      cfg,
   input  wire logic                   clear,
   input  wire logic                   pop_valid,
   output logic                        pop_ready,
   input  wire fbpa_pkg::cmd_type      pop_cmd,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output fbpa_pkg::rsp_word_type      rsp_word
);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_ACQ_MUL = 5'b00010,
      S_ACQ_UPD = 5'b00100,
      S_DIV     = 5'b01000,
      S_REL_UPD = 5'b10000
   } state_type;

   state_type                          state_ff, state_in;
   logic [fbpa_pkg::CNT_W-1:0]         head_ff, head_in;
   logic [fbpa_pkg::CNT_W-1:0]         used_count_ff, used_count_in;
   logic [fbpa_pkg::MAX_BLOCKS-1:0]    used_ff, used_in;
   logic [fbpa_pkg::MAX_BLOCKS-1:0]    link_valid_ff, link_valid_in;
   logic [fbpa_pkg::IDX_W-1:0]         idx_ff, idx_in;
   logic [fbpa_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic [fbpa_pkg::OFFU_W-1:0]        rem_ff, rem_in;
   logic [fbpa_pkg::IDX_W-1:0]         quot_ff, quot_in;
   logic [fbpa_pkg::STEP_W-1:0]        step_ff, step_in;
   logic                               out_valid_ff, out_valid_in;
   fbpa_pkg::rsp_word_type             out_ff, out_in;

   // free chain links; an entry not yet written links to its successor
   logic [fbpa_pkg::CNT_W-1:0]         link_mem [fbpa_pkg::MAX_BLOCKS];
   logic [fbpa_pkg::CNT_W-1:0]         link_rd_ff;
   logic                               link_we;

   logic [fbpa_pkg::DIV_W-1:0]         trial;
   logic [fbpa_pkg::OFFU_W-1:0]        rem_next;
   logic [fbpa_pkg::FIRST_W-1:0]       addr_sum;
   logic                               slot_free;

   assign slot_free = !out_valid_ff || rsp_ready;
   assign trial     = {1'b0, rem_ff}
                      - (fbpa_pkg::DIV_W'(cfg.stride_units) << step_ff);
   assign rem_next  = trial[fbpa_pkg::DIV_W-1] ? rem_ff : trial[fbpa_pkg::OFFU_W-1:0];
   assign addr_sum  = cfg.first_units + fbpa_pkg::FIRST_W'(prod_ff);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      used_count_in = used_count_ff;
      used_in       = used_ff;
      link_valid_in = link_valid_ff;
      idx_in        = idx_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      step_in       = step_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_in        = out_ff;
      link_we       = 1'b0;
      pop_ready     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            pop_ready = slot_free;
            if (pop_valid && slot_free) begin
               if (pop_cmd.opcode == fbpa_pkg::OP_ACQUIRE) begin
                  if (head_ff >= cfg.pool_count) begin
                     out_valid_in           = 1'b1;
                     out_in.status          = fbpa_pkg::STAT_EMPTY;
                     out_in.granted_address = '0;
                     out_in.blocks_in_use   = used_count_ff;
                  end else begin
                     idx_in   = head_ff[fbpa_pkg::IDX_W-1:0];
                     state_in = S_ACQ_MUL;
                  end
               end else if (pop_cmd.reject) begin
                  out_valid_in           = 1'b1;
                  out_in.status          = fbpa_pkg::STAT_NOT_OWNED;
                  out_in.granted_address = '0;
                  out_in.blocks_in_use   = used_count_ff;
               end else begin
                  rem_in   = pop_cmd.off_units;
                  quot_in  = '0;
                  step_in  = fbpa_pkg::STEP_W'(fbpa_pkg::IDX_W - 1);
                  state_in = S_DIV;
               end
            end
         end
         S_ACQ_MUL: begin
            prod_in  = fbpa_pkg::PROD_W'(idx_ff) * fbpa_pkg::PROD_W'(cfg.stride_units);
            state_in = S_ACQ_UPD;
         end
         S_ACQ_UPD: begin
            head_in                = link_valid_ff[idx_ff] ? link_rd_ff
                                     : fbpa_pkg::CNT_W'(idx_ff) + 1'b1;
            used_in[idx_ff]        = 1'b1;
            used_count_in          = used_count_ff + 1'b1;
            out_valid_in           = 1'b1;
            out_in.status          = fbpa_pkg::STAT_OK;
            out_in.granted_address = {addr_sum[fbpa_pkg::FIRST_W-2:0],
                                      fbpa_pkg::ALIGN_SHIFT'(0)};
            out_in.blocks_in_use   = used_count_ff + 1'b1;
            state_in               = S_IDLE;
         end
         S_DIV: begin
            // one quotient bit per cycle, most significant first
            rem_in = rem_next;
            if (!trial[fbpa_pkg::DIV_W-1]) begin
               quot_in = quot_ff | (fbpa_pkg::IDX_W'(1) << step_ff);
            end
            if (step_ff == '0) begin
               if (rem_next == '0) begin
                  state_in = S_REL_UPD;
               end else begin
                  out_valid_in           = 1'b1;
                  out_in.status          = fbpa_pkg::STAT_NOT_OWNED;
                  out_in.granted_address = '0;
                  out_in.blocks_in_use   = used_count_ff;
                  state_in               = S_IDLE;
               end
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         S_REL_UPD: begin
            out_valid_in           = 1'b1;
            out_in.granted_address = '0;
            if (!used_ff[quot_ff]) begin
               out_in.status        = fbpa_pkg::STAT_DOUBLE_FREE;
               out_in.blocks_in_use = used_count_ff;
            end else begin
               used_in[quot_ff]       = 1'b0;
               link_valid_in[quot_ff] = 1'b1;
               link_we                = 1'b1;
               head_in                = fbpa_pkg::CNT_W'(quot_ff);
               if (used_count_ff != '0) begin
                  used_count_in = used_count_ff - 1'b1;
               end
               out_in.status        = fbpa_pkg::STAT_OK;
               out_in.blocks_in_use = used_count_in;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a configuration write rebuilds the free chain
      if (clear) begin
         state_in      = S_IDLE;
         head_in       = '0;
         used_count_in = '0;
         used_in       = '0;
         link_valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         used_count_ff <= '0;
         used_ff       <= '0;
         link_valid_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         used_count_ff <= used_count_in;
         used_ff       <= used_in;
         link_valid_ff <= link_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
      out_ff  <= out_in;
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[quot_ff] <= head_ff;
      end
      link_rd_ff <= link_mem[head_ff[fbpa_pkg::IDX_W-1:0]];
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      used_count_ff <= cfg.pool_count)
      else $error("blocks in use exceed pool size");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= cfg.pool_count)
      else $error("free head beyond pool");

   a_div_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REL_UPD) |-> (fbpa_pkg::CNT_W'(quot_ff) < cfg.pool_count))
      else $error("release index outside pool");

   a_fail_no_grant: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status != fbpa_pkg::STAT_OK)
      |-> (out_ff.granted_address == '0))
      else $error("failed word carries an address");

endmodule

`default_nettype wire

// File: rtl/fixed_block_pool_allocator.sv
// an acquire goes from idle through the multiply and update states to the output register;
// a failed acquire or a rejected release is answered from idle; a release past the front
// checks runs eight restoring divide steps, one per cycle, then update, or is answered from
// the last divide step when the offset is not a whole number of strides; the back end works
// on one word at a time, and a two-entry command queue takes new words while a result waits
// to be taken; reset (synchronous, active high): block size 64, count 256, base 4096, all
// blocks free; a write to any of the three configuration registers rebuilds the free chain
`default_nettype none

module fixed_block_pool_allocator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   fbpa_req_if.sink                                req_bus,
   fbpa_rsp_if.source                              rsp_bus,
   input  wire logic                               csr_write_enable,
   input  wire logic [fbpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [fbpa_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   fbpa_pkg::cfg_type        cfg;
   logic                     clear;

   // front to queue
   logic                     push_valid;
   logic                     push_ready;
   fbpa_pkg::cmd_type        push_cmd;

   // queue to back
   logic                     pop_valid;
   logic                     pop_ready;
   fbpa_pkg::cmd_type        pop_cmd;

   // result word
   logic                     rsp_valid;
   fbpa_pkg::rsp_word_type   rsp_word;

   // configuration registers, size and base kept in alignment units
   fbpa_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg),
      .clear            (clear)
   );

   // front: range and alignment checks on release addresses
   fbpa_front u_front (
      .req_valid         (req_bus.valid),
      .req_opcode        (req_bus.opcode),
      .req_block_address (req_bus.block_address),
      .cfg               (cfg),
      .push_ready        (push_ready),
      .req_ready         (req_bus.ready),
      .push_valid        (push_valid),
      .push_cmd          (push_cmd)
   );

   // decouples classification from the free-list engine
   fbpa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // back: free chain, used marks, index divide and output register
   fbpa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .clear     (clear),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_word  (rsp_word)
   );

   assign rsp_bus.valid           = rsp_valid;
   assign rsp_bus.status          = rsp_word.status;
   assign rsp_bus.granted_address = rsp_word.granted_address;
   assign rsp_bus.blocks_in_use   = rsp_word.blocks_in_use;

endmodule

`default_nettype wire

// File: test/fixed_block_pool_allocator_tb.sv
module fixed_block_pool_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fbpa_pkg::*;

   // stimulus size and pacing
   localparam int ITEM_TARGET   = 1450;
   localparam int CALM_ITEMS    = 150;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 400;
   localparam int STUCK_LIMIT   = 4000;

   // mirror of the pool: geometry, lifo free chain, in-use marks and the
   // words still owed by the block
   class pool_tracker;
      logic [SIZE_W-1:0] size_reg;
      logic [CNT_W-1:0]  count_reg;
      logic [ADDR_W-1:0] base_reg;
      bit [63:0]         stride;
      bit [63:0]         first;
      int                blocks;
      bit [CNT_W-1:0]    next_free[MAX_BLOCKS];
      bit                taken[MAX_BLOCKS];
      int                head;
      int                in_use;
      rsp_word_type      owed_replies[$];
      int                mismatches;

      function new();
         size_reg   = SIZE_W'(RST_BLOCK_SIZE);
         count_reg  = CNT_W'(RST_BLOCK_COUNT);
         base_reg   = ADDR_W'(RST_BASE);
         mismatches = 0;
         rebuild();
      endfunction

      function void rebuild();
         int n;
         n = (count_reg > MAX_BLOCKS) ? MAX_BLOCKS : int'(count_reg);
         blocks = (size_reg == 0 || n == 0) ? 0 : n;
         stride = (blocks == 0) ? 64'd0
                  : ((64'(size_reg) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
         first = ((64'(base_reg) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
         for (int i = 0; i < MAX_BLOCKS; i++) begin
            next_free[i] = CNT_W'(i + 1);
            taken[i]     = 1'b0;
         end
         head   = 0;
         in_use = 0;
      endfunction

      function void configure(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            REG_BLOCK_SIZE:   size_reg  = value[SIZE_W-1:0];
            REG_BLOCK_COUNT:  count_reg = value[CNT_W-1:0];
            REG_BASE_ADDRESS: base_reg  = value[ADDR_W-1:0];
            default:          return;
         endcase
         rebuild();
      endfunction

      function logic [ADDR_W-1:0] block_addr(int idx);
         bit [63:0] full;
         full = first + 64'(idx) * stride;
         return full[ADDR_W-1:0];
      endfunction

      function logic [ADDR_W-1:0] random_taken_addr(output bit found);
         int held[$];
         for (int i = 0; i < blocks; i++)
            if (taken[i]) held.push_back(i);
         found = (held.size() != 0);
         if (!found) return '0;
         return block_addr(held[$urandom_range(held.size() - 1)]);
      endfunction

      // work out the reply word for an accepted request and queue it
      function void take_request(op_type op, logic [ADDR_W-1:0] addr);
         rsp_word_type w;
         bit [63:0]    a;
         bit [63:0]    off;
         int           idx;
         a = 64'(addr);
         w.status          = STAT_OK;
         w.granted_address = '0;
         if (op == OP_ACQUIRE) begin
            if (head >= blocks) begin
               w.status = STAT_EMPTY;
            end else begin
               idx       = head;
               head      = int'(next_free[idx]);
               taken[idx] = 1'b1;
               in_use++;
               w.granted_address = block_addr(idx);
            end
         end else if (a == 0 || blocks == 0 || a < first) begin
            w.status = STAT_NOT_OWNED;
         end else begin
            off = a - first;
            if (off >= stride * 64'(blocks) || off % stride != 0) begin
               w.status = STAT_NOT_OWNED;
            end else begin
               idx = int'(off / stride);
               if (!taken[idx]) begin
                  w.status = STAT_DOUBLE_FREE;
               end else begin
                  taken[idx]     = 1'b0;
                  next_free[idx] = CNT_W'(head);
                  head           = idx;
                  if (in_use > 0) in_use--;
               end
            end
         end
         w.blocks_in_use = CNT_W'(in_use);
         owed_replies.push_back(w);
      endfunction

      function void check_reply(logic [1:0] st, logic [ADDR_W-1:0] ga, logic [CNT_W-1:0] biu);
         rsp_word_type w;
         if (owed_replies.size() == 0) begin
            $display("%0t: unexpected reply word: status %0d address %0h in use %0d",
                     $time, st, ga, biu);
            mismatches++;
            return;
         end
         w = owed_replies.pop_front();
         if (st !== w.status) begin
            $display("%0t: status expected %0d actual %0d", $time, w.status, st);
            mismatches++;
         end
         if (ga !== w.granted_address) begin
            $display("%0t: granted address expected %0h actual %0h",
                     $time, w.granted_address, ga);
            mismatches++;
         end
         if (biu !== w.blocks_in_use) begin
            $display("%0t: blocks in use expected %0d actual %0d",
                     $time, w.blocks_in_use, biu);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   fbpa_req_if req_bus ();
   fbpa_rsp_if rsp_bus ();

   pool_tracker tracker = new();

   // pacing knobs shared by the request and reply sides
   int gap_pct      = 20;
   int stall_pct    = 20;
   bit calm         = 1'b0;
   bit hold_request = 1'b0;
   int stuck_cycles = 0;

   fixed_block_pool_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   // offer one request word, optionally after a random gap, and note it
   // at the edge where it is taken
   task automatic offer_word(input op_type op, input logic [ADDR_W-1:0] addr);
      if (!calm && $urandom_range(99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.opcode        <= op;
      req_bus.block_address <= addr;
      // ready is settled by the falling edge, so the next rising edge takes it
      do @(negedge clock); while (!req_bus.ready);
      @(posedge clock);
      tracker.take_request(op, addr);
   endtask

   // stop offering, wait for every owed reply, then let the back end go idle
   task automatic wait_quiet();
      req_bus.valid <= 1'b0;
      while (tracker.owed_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all three registers on back-to-back edges; each write rebuilds the chain
   task automatic program_pool(input logic [SIZE_W-1:0] size, input logic [CNT_W-1:0] count,
                               input logic [ADDR_W-1:0] base);
      csr_write_enable <= 1'b1;
      csr_index        <= REG_BLOCK_SIZE;
      csr_write_data   <= CSR_DATA_W'(size);
      @(posedge clock);
      tracker.configure(REG_BLOCK_SIZE, CSR_DATA_W'(size));
      csr_index        <= REG_BLOCK_COUNT;
      csr_write_data   <= CSR_DATA_W'(count);
      @(posedge clock);
      tracker.configure(REG_BLOCK_COUNT, CSR_DATA_W'(count));
      csr_index        <= REG_BASE_ADDRESS;
      csr_write_data   <= base;
      @(posedge clock);
      tracker.configure(REG_BASE_ADDRESS, base);
      csr_write_enable <= 1'b0;
   endtask

   // reply side: random stall bursts, one long hold-off on request, none when calm
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (!calm && $urandom_range(99) < stall_pct) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // every reply word taken is compared against the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_reply(rsp_bus.status, rsp_bus.granted_address, rsp_bus.blocks_in_use);
   end

   // watchdog: too long without any word moving on either side
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      logic [SIZE_W-1:0] size;
      logic [CNT_W-1:0]  count;
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] addr;
      op_type            op;
      bit                found;
      int                issued;
      int                phase_no;
      int                phase_len;
      int                acquire_pct;
      int                pick;
      int                idx_pick;

      // every input known from the start
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.opcode        <= OP_ACQUIRE;
      req_bus.block_address <= '0;
      rsp_bus.ready         <= 1'b0;
      csr_write_enable      <= 1'b0;
      csr_index             <= REG_BLOCK_SIZE;
      csr_write_data        <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry: 64-byte stride, 256 blocks from 4096
      offer_word(OP_ACQUIRE, '0);
      offer_word(OP_ACQUIRE, 48'hFFFF_FFFF_FFFF);     // address ignored on acquire
      offer_word(OP_RELEASE, 48'd4160);
      offer_word(OP_RELEASE, 48'd4160);               // second free of the same block
      offer_word(OP_RELEASE, 48'd0);                  // null
      offer_word(OP_RELEASE, 48'd4095);               // just under the pool
      offer_word(OP_RELEASE, 48'd4097);               // off the stride
      offer_word(OP_RELEASE, 48'd4096 + 48'd64 * 256); // one past the last block
      offer_word(OP_RELEASE, 48'hFFFF_FFFF_FFFF);
      offer_word(OP_ACQUIRE, '0);                     // lifo hands back 4160
      offer_word(OP_RELEASE, 48'd4096 + 48'd64 * 255); // last block, never taken
      wait_quiet();

      // zero block size: inert pool
      program_pool('0, 9'd256, 48'd4096);
      offer_word(OP_ACQUIRE, '0);
      offer_word(OP_RELEASE, 48'd4096);
      wait_quiet();

      // single block, 128-byte stride, base rounded up to 64
      program_pool(17'd100, 9'd1, 48'd1);
      offer_word(OP_ACQUIRE, '0);
      offer_word(OP_ACQUIRE, '0);                     // chain empty
      offer_word(OP_RELEASE, 48'd128);                // inside the stride, not on a block boundary
      offer_word(OP_RELEASE, 48'd64);
      wait_quiet();

      // oversized count saturates; largest stride wraps past the top of memory
      program_pool(17'd65536, 9'd300, 48'hFFFF_FFFE_0000);
      offer_word(OP_ACQUIRE, '0);
      offer_word(OP_ACQUIRE, '0);
      offer_word(OP_ACQUIRE, '0);                     // wraps to zero
      offer_word(OP_RELEASE, 48'd0);
      wait_quiet();

      // zero count at the top base: inert
      program_pool(17'd64, 9'd0, 48'hFFFF_FFFF_FFFF);
      offer_word(OP_ACQUIRE, '0);
      wait_quiet();

      // base rounds up past the top, so every grant wraps below it
      program_pool(17'd1, 9'd2, 48'hFFFF_FFFF_FFFF);
      offer_word(OP_ACQUIRE, '0);
      offer_word(OP_ACQUIRE, '0);
      offer_word(OP_RELEASE, 48'd64);
      wait_quiet();

      // random phases, each on a fresh geometry
      issued   = 0;
      phase_no = 0;
      while (issued < ITEM_TARGET) begin
         case ($urandom_range(9))
            0:       size = '0;
            1:       size = 17'd1;
            2:       size = 17'd64;
            3:       size = 17'd65536;
            4:       size = 17'd65;
            5:       size = SIZE_W'($urandom_range(1, 65536));
            default: size = SIZE_W'($urandom_range(1, 512));
         endcase
         case ($urandom_range(9))
            0:       count = '0;
            1:       count = 9'd1;
            2:       count = 9'd256;
            3:       count = CNT_W'($urandom_range(257, 511));
            4, 5, 6: count = CNT_W'($urandom_range(1, 8));
            default: count = CNT_W'($urandom_range(1, 256));
         endcase
         case ($urandom_range(7))
            0:       base = '0;
            1:       base = 48'hFFFF_FFFF_FFFF;
            2:       base = 48'hFFFF_FFFF_FFFF - ADDR_W'($urandom_range(0, 1 << 20));
            3:       base = ADDR_W'({$urandom, $urandom});
            default: base = ADDR_W'($urandom_range(0, 1 << 20));
         endcase
         program_pool(size, count, base);

         phase_len = (tracker.blocks == 0) ? $urandom_range(8, 16) : $urandom_range(40, 100);
         case ($urandom_range(3))
            0:       acquire_pct = 30;
            1:       acquire_pct = 50;
            2:       acquire_pct = 70;
            default: acquire_pct = 90;
         endcase
         gap_pct   = $urandom_range(1) ? 0 : 30;
         stall_pct = $urandom_range(1) ? 0 : 30;
         // one phase where replies are held back long enough to back up the input
         if (phase_no == 2) begin
            gap_pct      = 0;
            hold_request = 1'b1;
         end

         for (int k = 0; k < phase_len && issued < ITEM_TARGET; k++) begin
            if (issued >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
            addr = ADDR_W'({$urandom, $urandom});
            op   = OP_ACQUIRE;
            if ($urandom_range(99) >= acquire_pct) begin
               op       = OP_RELEASE;
               pick     = $urandom_range(99);
               idx_pick = (tracker.blocks == 0) ? 0 : $urandom_range(tracker.blocks - 1);
               if (pick < 70) begin
                  // mostly hand back something that is really held
                  addr = tracker.random_taken_addr(found);
                  if (!found) addr = tracker.block_addr(idx_pick);
               end else if (pick < 80) begin
                  addr = tracker.block_addr(idx_pick);
               end else if (pick < 86) begin
                  if (tracker.stride != 0)
                     addr = tracker.block_addr(idx_pick)
                            + ADDR_W'($urandom_range(1, int'(tracker.stride) - 1));
               end else if (pick < 89) begin
                  addr = '0;
               end else if (pick < 92) begin
                  addr = ADDR_W'(tracker.first + tracker.stride * 64'(tracker.blocks));
               end else if (pick < 95) begin
                  addr = ADDR_W'(tracker.first - ALIGN_BYTES);
               end
            end
            offer_word(op, addr);
            issued++;
         end
         wait_quiet();
         phase_no++;
      end

      if (tracker.mismatches == 0 && tracker.owed_replies.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
